FILE: rtl/mde_pkg.sv
package mde_pkg;

  localparam int DELAY_DEPTH_DEF  = 131072;
  localparam int CHANNELS_DEF     = 2;
  localparam int SINE_ENTRIES_DEF = 1024;

  localparam int LP_COEF   = 11469;
  localparam int MOD_SCALE = 983;

  localparam logic [2:0] REG_DELAY_BASE = 3'd0;
  localparam logic [2:0] REG_FEEDBACK   = 3'd1;
  localparam logic [2:0] REG_MOD_DEPTH  = 3'd2;
  localparam logic [2:0] REG_BLEND      = 3'd3;
  localparam logic [2:0] REG_LFO_STEP   = 3'd4;

  typedef struct packed {
    logic               channel;
    logic signed [23:0] sample_in;
  } in_item_t;

  typedef struct packed {
    logic               channel_out;
    logic signed [23:0] sample_out;
  } out_item_t;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SINE,
    ST_MOD1,
    ST_MOD2,
    ST_DLY,
    ST_POS,
    ST_RDA,
    ST_RDB,
    ST_WAITB,
    ST_INTA,
    ST_INTB,
    ST_LP,
    ST_FB,
    ST_WR,
    ST_MIXA,
    ST_MIXB,
    ST_OUT
  } state_t;

  // Sine in Q1.15 at phase t (32-bit phase fraction); polynomial on the folded
  // quarter wave.
  function automatic logic signed [15:0] sine_entry(input logic [63:0] t);
    logic [1:0]  quad;
    logic [63:0] z;
    logic [63:0] z2;
    logic [63:0] p;
    logic [63:0] r;
    logic [63:0] q15;
    quad = t[31:30];
    z = {34'd0, t[29:0]};
    if (quad[0]) z = (64'd1 << 30) - z;
    z2 = (z * z) >> 30;
    p = 64'd5026996 - ((z2 * 64'd172272) >> 30);
    p = 64'd85569306 - ((z2 * p) >> 30);
    p = 64'd693598669 - ((z2 * p) >> 30);
    p = 64'd1686629713 - ((z2 * p) >> 30);
    r = (z * p) >> 30;
    q15 = (r + 64'd16384) >> 15;
    if (q15 > 64'd32767) q15 = 64'd32767;
    sine_entry = quad[1] ? -$signed(16'(q15)) : $signed(16'(q15));
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [49:0] x);
    if (x > 50'sd8388607) sat24 = 24'sh7FFFFF;
    else if (x < -50'sd8388608) sat24 = 24'sh800000;
    else sat24 = x[23:0];
  endfunction

endpackage

FILE: rtl/modulated_delay_echo.sv
// Channel  Handshake            Payload
// in_      in_valid/in_ready    mde_pkg::in_item_t  (channel, sample_in)
// out_     out_valid/out_ready  mde_pkg::out_item_t (channel_out, sample_out)
// cfg_     cfg_we               cfg_index, cfg_data
// Each request runs through the states ST_SINE to ST_OUT; one 26x26 multiplier
// and the delay RAM (one read and one write port) are shared among the steps.
// After reset a clearing pass writes every RAM word, with in_ready low;
// configuration writes are taken meanwhile.
// The next request is taken once the result has left the output register.
module modulated_delay_echo #(
  parameter int DELAY_DEPTH  = mde_pkg::DELAY_DEPTH_DEF,
  parameter int CHANNELS     = mde_pkg::CHANNELS_DEF,
  parameter int SINE_ENTRIES = mde_pkg::SINE_ENTRIES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  mde_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output mde_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  localparam int AW  = $clog2(DELAY_DEPTH);
  localparam int CW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int MW  = CW + AW;
  localparam int SW  = $clog2(SINE_ENTRIES);
  localparam int PW  = AW + 8;
  localparam logic [AW-1:0] LAST_POS = AW'(DELAY_DEPTH - 1);
  localparam logic [CW-1:0] LAST_CH  = CW'(CHANNELS - 1);

  logic signed [15:0] sine_rom [SINE_ENTRIES];
  for (genvar k = 0; k < SINE_ENTRIES; k++) begin : g_rom
    localparam logic [63:0] PHASE_T = (64'(k) << 32) / 64'(SINE_ENTRIES);
    assign sine_rom[k] = mde_pkg::sine_entry(PHASE_T);
  end

  logic signed [23:0] mem [CHANNELS*DELAY_DEPTH];
  logic               mem_we;
  logic [MW-1:0]      mem_waddr;
  logic [MW-1:0]      mem_raddr;
  logic signed [23:0] mem_wdata;
  logic signed [23:0] mem_q_r;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    mem_q_r <= mem[mem_raddr];
  end

  logic [24:0] delay_base_r;
  logic [14:0] feedback_r;
  logic [15:0] depth_r;
  logic [15:0] blend_r;
  logic [31:0] lfo_step_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_base_r <= 25'd1228800;
      feedback_r   <= '0;
      depth_r      <= '0;
      blend_r      <= '0;
      lfo_step_r   <= 32'd107374;
    end else if (cfg_we) begin
      case (cfg_index)
        mde_pkg::REG_DELAY_BASE: delay_base_r <= cfg_data[24:0];
        mde_pkg::REG_FEEDBACK:   feedback_r   <= cfg_data[14:0];
        mde_pkg::REG_MOD_DEPTH:  depth_r      <= cfg_data[15:0];
        mde_pkg::REG_BLEND:      blend_r      <= cfg_data[15:0];
        mde_pkg::REG_LFO_STEP:   lfo_step_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  mde_pkg::state_t state_r, state_nxt;

  logic [AW-1:0]      wpos_r  [CHANNELS];
  logic signed [23:0] lp_r    [CHANNELS];
  logic [31:0]        phase_r [CHANNELS];

  logic [MW-1:0]      clr_r;
  logic [CW-1:0]      ch_r;
  logic signed [23:0] x_r;
  logic signed [49:0] acc_r;
  logic signed [23:0] a_r;
  logic [7:0]         frac_r;
  logic [AW-1:0]      idx_r;
  logic signed [23:0] lp_new_r;
  logic signed [23:0] res_r;
  logic               ovalid_r;

  // Shared multiplier, operands selected by state.
  logic signed [25:0] mul_a;
  logic signed [25:0] mul_b;
  logic signed [51:0] mul_p;
  logic signed [49:0] mul_lo;
  assign mul_p  = mul_a * mul_b;
  assign mul_lo = mul_p[49:0];

  logic [CW-1:0] in_ch;
  assign in_ch = (32'(in_data.channel) >= CHANNELS) ? LAST_CH : CW'(in_data.channel);

  logic [SW-1:0] sidx;
  assign sidx = phase_r[ch_r][31 -: SW];

  logic signed [16:0] g;
  assign g = (blend_r > 16'd32768) ? 17'sd32768 : $signed({1'b0, blend_r});

  // Read position: wp*256 - d modulo the span; the low PW bits are exact
  // when the span is a power of two.
  logic [PW-1:0] rp;
  assign rp = {wpos_r[ch_r], 8'd0} - acc_r[PW-1:0];

  logic [AW-1:0] idx_next;
  assign idx_next = (idx_r == LAST_POS) ? AW'(0) : idx_r + AW'(1);

  logic signed [49:0] lp_sum;
  assign lp_sum = 50'(lp_r[ch_r]) + (mul_lo >>> 15);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      mde_pkg::ST_MOD1: begin
        mul_a = 26'(acc_r);
        mul_b = 26'(mde_pkg::MOD_SCALE);
      end
      mde_pkg::ST_MOD2: begin
        mul_a = 26'(acc_r);
        mul_b = $signed({10'd0, depth_r});
      end
      // Delay term: base*m needs the full product width before the shift.
      mde_pkg::ST_DLY: begin
        mul_a = $signed({1'b0, delay_base_r});
        mul_b = 26'(acc_r);
      end
      mde_pkg::ST_INTA: begin
        mul_a = 26'(a_r);
        mul_b = $signed({17'd0, 9'd256 - {1'b0, frac_r}});
      end
      mde_pkg::ST_INTB: begin
        mul_a = 26'(mem_q_r);
        mul_b = $signed({18'd0, frac_r});
      end
      mde_pkg::ST_LP: begin
        mul_a = 26'(acc_r) - 26'(lp_r[ch_r]);
        mul_b = 26'(mde_pkg::LP_COEF);
      end
      mde_pkg::ST_FB: begin
        mul_a = 26'(lp_new_r);
        mul_b = $signed({11'd0, feedback_r});
      end
      mde_pkg::ST_MIXA: begin
        mul_a = 26'(x_r);
        mul_b = 26'(17'sd32768 - g);
      end
      mde_pkg::ST_MIXB: begin
        mul_a = 26'(lp_new_r);
        mul_b = 26'(g);
      end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mde_pkg::ST_CLEAR: if (clr_r == MW'(CHANNELS*DELAY_DEPTH - 1)) state_nxt = mde_pkg::ST_IDLE;
      mde_pkg::ST_IDLE:  if (in_valid && !ovalid_r) state_nxt = mde_pkg::ST_SINE;
      mde_pkg::ST_SINE:  state_nxt = mde_pkg::ST_MOD1;
      mde_pkg::ST_MOD1:  state_nxt = mde_pkg::ST_MOD2;
      mde_pkg::ST_MOD2:  state_nxt = mde_pkg::ST_DLY;
      mde_pkg::ST_DLY:   state_nxt = mde_pkg::ST_POS;
      mde_pkg::ST_POS:   state_nxt = mde_pkg::ST_RDA;
      mde_pkg::ST_RDA:   state_nxt = mde_pkg::ST_RDB;
      mde_pkg::ST_RDB:   state_nxt = mde_pkg::ST_WAITB;
      mde_pkg::ST_WAITB: state_nxt = mde_pkg::ST_INTA;
      mde_pkg::ST_INTA:  state_nxt = mde_pkg::ST_INTB;
      mde_pkg::ST_INTB:  state_nxt = mde_pkg::ST_LP;
      mde_pkg::ST_LP:    state_nxt = mde_pkg::ST_FB;
      mde_pkg::ST_FB:    state_nxt = mde_pkg::ST_WR;
      mde_pkg::ST_WR:    state_nxt = mde_pkg::ST_MIXA;
      mde_pkg::ST_MIXA:  state_nxt = mde_pkg::ST_MIXB;
      mde_pkg::ST_MIXB:  state_nxt = mde_pkg::ST_OUT;
      mde_pkg::ST_OUT:   state_nxt = mde_pkg::ST_IDLE;
      default:           state_nxt = mde_pkg::ST_IDLE;
    endcase
  end

  // The first tap is read in ST_RDA; the second tap's address is held from
  // then on so that its word stays on the RAM output through ST_INTB.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = {ch_r, wpos_r[ch_r]};
    mem_wdata = mde_pkg::sat24(50'(x_r) + acc_r);
    mem_raddr = {ch_r, idx_next};
    case (state_r)
      mde_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        mem_wdata = '0;
      end
      mde_pkg::ST_RDA: mem_raddr = {ch_r, idx_r};
      mde_pkg::ST_WR:  mem_we = 1'b1;
      default: ;
    endcase
  end

  assign in_ready  = (state_r == mde_pkg::ST_IDLE) && !ovalid_r;
  assign out_valid = ovalid_r;
  assign out_data.channel_out = 1'(ch_r);
  assign out_data.sample_out  = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= mde_pkg::ST_CLEAR;
      clr_r    <= '0;
      ovalid_r <= 1'b0;
      for (int c = 0; c < CHANNELS; c++) begin
        wpos_r[c]  <= '0;
        lp_r[c]    <= '0;
        phase_r[c] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (state_r == mde_pkg::ST_CLEAR) clr_r <= clr_r + MW'(1);
      if (state_r == mde_pkg::ST_OUT) begin
        ovalid_r       <= 1'b1;
        lp_r[ch_r]     <= lp_new_r;
        wpos_r[ch_r]   <= (wpos_r[ch_r] == LAST_POS) ? AW'(0) : wpos_r[ch_r] + AW'(1);
        phase_r[ch_r]  <= phase_r[ch_r] + lfo_step_r;
      end else if (out_valid && out_ready) begin
        ovalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      mde_pkg::ST_IDLE: begin
        if (in_valid && in_ready) begin
          ch_r <= in_ch;
          x_r  <= in_data.sample_in;
        end
      end
      mde_pkg::ST_SINE:  acc_r <= 50'(sine_rom[sidx]);
      mde_pkg::ST_MOD1:  acc_r <= mul_lo;
      mde_pkg::ST_MOD2:  acc_r <= mul_lo >>> 16;
      mde_pkg::ST_DLY:   acc_r <= 50'($signed({1'b0, delay_base_r})) + 50'(mul_p >>> 31);
      mde_pkg::ST_POS: begin
        idx_r  <= rp[PW-1:8];
        frac_r <= rp[7:0];
      end
      mde_pkg::ST_RDB:   a_r <= mem_q_r;
      mde_pkg::ST_INTA:  acc_r <= mul_lo;
      mde_pkg::ST_INTB:  acc_r <= (acc_r + mul_lo) >>> 8;
      mde_pkg::ST_LP:    lp_new_r <= mde_pkg::sat24(lp_sum);
      mde_pkg::ST_FB:    acc_r <= mul_lo >>> 15;
      mde_pkg::ST_MIXA:  acc_r <= mul_lo;
      mde_pkg::ST_MIXB:  res_r <= mde_pkg::sat24((acc_r + mul_lo) >>> 15);
      default: ;
    endcase
  end

`ifndef SYNTH
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != mde_pkg::ST_IDLE) |-> !in_ready)
    else $error("request accepted while busy");
  a_result_after_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mde_pkg::ST_OUT) |=> out_valid)
    else $error("result not presented");
  a_write_once: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && state_r != mde_pkg::ST_CLEAR) |-> (state_r == mde_pkg::ST_WR))
    else $error("stray memory write");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("result changed under stall");
`endif

endmodule
